>>> rtl/core/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants for the size-class pool allocator: default geometry,
// request field widths, status codes and the chunk limit register.
// ----------------------------------------------------------------------------
package scpa_pkg;

    // Default heap geometry
    localparam int POOL_CLASSES_DEF = 16;
    localparam int CHUNK_BLOCKS_DEF = 256;
    localparam int HEAP_BLOCKS_DEF  = 4096;

    // Request size field and block rounding (8-byte blocks)
    localparam int SIZE_W      = 8;
    localparam int BLOCK_SHIFT = 3;
    localparam int BLK_W       = SIZE_W + 1 - BLOCK_SHIFT;

    // Chunk limit register
    localparam int              LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam int               STATUS_W   = 2;
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd2;

endpackage

>>> rtl/core/size_class_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// Segregated free-list allocator over a heap of 8-byte blocks: per-class
// LIFO lists held in a head memory and a link memory, plus a chunk carver.
// ----------------------------------------------------------------------------
// Sequence: free and bad-size requests answer after the head read; allocate
//   from a free list after the head read, then the link read; carve after
//   the head read, or after a read of the remainder's class head when the
//   old chunk's remainder is pushed first. A full output register adds stall.
// Flow: one request at a time; head and link memory reads are registered.
// Reset: all lists empty through per-class valid flops, no clearing pass;
//   the link memory is not reset. Chunk limit resets to 16.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_core
    import scpa_pkg::*;
#(
    parameter int POOL_CLASSES = POOL_CLASSES_DEF,
    parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF,
    parameter int HEAP_BLOCKS  = HEAP_BLOCKS_DEF,
    localparam int ADDR_W      = $clog2(HEAP_BLOCKS),
    localparam int GRANT_W     = $clog2(POOL_CLASSES + 1),
    localparam int IN_DATA_W   = ((SIZE_W + ADDR_W + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((ADDR_W + GRANT_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: heap_chunk_limit
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_W-1:0]    cfg_wr_data,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // size_bytes, free_block_addr
    input  logic                  s_tuser,   // req_type
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // block_addr, blocks_granted
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    localparam int CLS_W      = (POOL_CLASSES > 1) ? $clog2(POOL_CLASSES) : 1;
    localparam int PTR_W      = $clog2(HEAP_BLOCKS + 1);
    localparam int REM_W      = $clog2(CHUNK_BLOCKS + 1);
    localparam int MAX_CHUNKS = HEAP_BLOCKS / CHUNK_BLOCKS;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    // Control and request registers
    logic [1:0]           state_reg, state_next;
    logic                 req_free_reg;
    logic                 bad_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic [GRANT_W-1:0]   blocks_reg;
    logic [ADDR_W-1:0]    faddr_reg;

    // List storage
    logic [ADDR_W-1:0]    head_mem [POOL_CLASSES];
    logic [POOL_CLASSES-1:0] head_valid_reg;
    logic [ADDR_W-1:0]    head_rd_reg;
    logic [ADDR_W:0]      link_mem [HEAP_BLOCKS];
    logic [ADDR_W:0]      link_rd_reg;

    // Carver state
    logic [PTR_W-1:0]     carve_ptr_reg, carve_ptr_next;
    logic [REM_W-1:0]     carve_rem_reg, carve_rem_next;
    logic [PTR_W-1:0]     chunk_base_reg, chunk_base_next;
    logic [CNT_W-1:0]     chunks_taken_reg, chunks_taken_next;
    logic [LIMIT_W-1:0]   limit_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    // Combinational request decode
    logic                 in_accept;
    logic [SIZE_W:0]      in_blk_sum;
    logic [BLK_W-1:0]     in_blk;
    logic [ADDR_W-1:0]    in_faddr;
    logic                 in_bad;

    // Memory port controls
    logic                 head_re;
    logic [CLS_W-1:0]     head_raddr;
    logic                 head_we;
    logic [CLS_W-1:0]     head_waddr;
    logic [ADDR_W-1:0]    head_wdata;
    logic                 valid_we;
    logic                 valid_wval;
    logic                 link_re;
    logic                 link_we;
    logic [ADDR_W-1:0]    link_waddr;
    logic [ADDR_W:0]      link_wdata;

    // Carve and result signals
    logic                 can_emit;
    logic                 emit;
    logic [STATUS_W-1:0]  res_status;
    logic [ADDR_W-1:0]    res_addr;
    logic [GRANT_W-1:0]   res_blocks;
    logic                 head_cur_valid;
    logic [CLS_W-1:0]     rem_cls;
    logic                 need_chunk;
    logic                 exhausted;
    logic [PTR_W-1:0]     carve_base;
    logic [REM_W-1:0]     carve_avail;
    logic                 carve_commit;
    logic                 head_in_heap;

    assign in_accept  = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_blk_sum = {1'b0, s_tdata[SIZE_W-1:0]} + (SIZE_W+1)'(7);
    assign in_blk     = in_blk_sum[SIZE_W:BLOCK_SHIFT];
    assign in_faddr   = s_tdata[SIZE_W +: ADDR_W];
    assign in_bad     = (in_blk == '0) || (32'(in_blk) > POOL_CLASSES)
                     || ((s_tuser == REQ_FREE) && (32'(in_faddr) >= HEAP_BLOCKS));

    assign can_emit       = !m_tvalid_reg || m_tready;
    assign head_cur_valid = head_valid_reg[cls_reg];
    assign rem_cls        = CLS_W'(carve_rem_reg - REM_W'(1));
    assign head_in_heap   = (32'(head_rd_reg) < HEAP_BLOCKS);

    // Carve source: the current chunk, or a fresh one
    assign need_chunk  = (state_reg == S_REM) || (32'(blocks_reg) > 32'(carve_rem_reg));
    assign exhausted   = (32'(chunks_taken_reg) >= 32'(limit_reg))
                      || (32'(chunks_taken_reg) >= MAX_CHUNKS);
    assign carve_base  = need_chunk ? chunk_base_reg : carve_ptr_reg;
    assign carve_avail = need_chunk ? REM_W'(CHUNK_BLOCKS) : carve_rem_reg;

    // Sequence one request through head read, optional link or head read, result
    always_comb
    begin
        state_next   = state_reg;
        head_re      = 1'b0;
        head_raddr   = cls_reg;
        head_we      = 1'b0;
        head_waddr   = cls_reg;
        head_wdata   = faddr_reg;
        valid_we     = 1'b0;
        valid_wval   = 1'b1;
        link_re      = 1'b0;
        link_we      = 1'b0;
        link_waddr   = faddr_reg;
        link_wdata   = {head_cur_valid, head_rd_reg};
        emit         = 1'b0;
        carve_commit = 1'b0;
        res_status   = ST_OK;
        res_addr     = '0;
        res_blocks   = blocks_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    head_re    = 1'b1;
                    head_raddr = CLS_W'(in_blk - BLK_W'(1));
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (bad_reg)
                begin
                    emit       = 1'b1;
                    res_status = ST_BADSIZE;
                    res_blocks = '0;
                end
                else if (req_free_reg == REQ_FREE)
                begin
                    // Push the freed piece onto its class
                    emit     = 1'b1;
                    head_we  = can_emit;
                    valid_we = can_emit;
                    link_we  = can_emit;
                end
                else if (head_cur_valid)
                begin
                    // Pop: fetch the successor link
                    link_re    = head_in_heap;
                    state_next = S_POP;
                end
                else if ((32'(blocks_reg) > 32'(carve_rem_reg)) && (carve_rem_reg != '0)
                         && (32'(carve_ptr_reg) < HEAP_BLOCKS))
                begin
                    // Fetch the remainder's class head before retiring the chunk
                    head_re    = 1'b1;
                    head_raddr = rem_cls;
                    state_next = S_REM;
                end
                else
                begin
                    emit         = 1'b1;
                    carve_commit = can_emit;
                end
                if (emit && can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                // Push the old chunk's remainder, then carve from a fresh chunk
                emit         = 1'b1;
                carve_commit = can_emit;
                head_we      = can_emit;
                head_waddr   = rem_cls;
                head_wdata   = ADDR_W'(carve_ptr_reg);
                valid_we     = can_emit;
                link_we      = can_emit;
                link_waddr   = ADDR_W'(carve_ptr_reg);
                link_wdata   = {head_valid_reg[rem_cls], head_rd_reg};
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                // Advance the head to the successor
                emit       = 1'b1;
                res_addr   = head_rd_reg;
                head_we    = can_emit;
                valid_we   = can_emit;
                head_wdata = head_in_heap ? link_rd_reg[ADDR_W-1:0] : '0;
                valid_wval = head_in_heap ? link_rd_reg[ADDR_W] : 1'b0;
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Carve result
        if ((state_reg == S_REM) || ((state_reg == S_HEAD) && emit && !bad_reg
                                     && (req_free_reg == REQ_ALLOC)))
        begin
            if (need_chunk && exhausted)
            begin
                res_status = ST_NOMEM;
                res_addr   = '0;
                res_blocks = '0;
            end
            else
            begin
                res_addr = ADDR_W'(carve_base);
            end
        end
    end

    // Next carver state
    always_comb
    begin
        carve_ptr_next    = carve_ptr_reg;
        carve_rem_next    = carve_rem_reg;
        chunk_base_next   = chunk_base_reg;
        chunks_taken_next = chunks_taken_reg;
        if (carve_commit)
        begin
            if (need_chunk && exhausted)
            begin
                carve_rem_next = '0;
            end
            else
            begin
                carve_ptr_next = carve_base + PTR_W'(blocks_reg);
                carve_rem_next = carve_avail - REM_W'(blocks_reg);
                if (need_chunk)
                begin
                    chunk_base_next   = chunk_base_reg + PTR_W'(CHUNK_BLOCKS);
                    chunks_taken_next = chunks_taken_reg + CNT_W'(1);
                end
            end
        end
    end

    // Control, carver and list valid flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_valid_reg   <= '0;
            carve_ptr_reg    <= '0;
            carve_rem_reg    <= '0;
            chunk_base_reg   <= '0;
            chunks_taken_reg <= '0;
            limit_reg        <= LIMIT_RESET;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            carve_ptr_reg    <= carve_ptr_next;
            carve_rem_reg    <= carve_rem_next;
            chunk_base_reg   <= chunk_base_next;
            chunks_taken_reg <= chunks_taken_next;
            if (valid_we)
            begin
                head_valid_reg[head_waddr] <= valid_wval;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (emit && can_emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Latch the request and load the result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_free_reg <= s_tuser;
            bad_reg      <= in_bad;
            cls_reg      <= CLS_W'(in_blk - BLK_W'(1));
            blocks_reg   <= GRANT_W'(in_blk);
            faddr_reg    <= in_faddr;
        end
        if (emit && can_emit)
        begin
            m_tdata_reg <= OUT_DATA_W'({res_blocks, res_addr});
            m_tuser_reg <= res_status;
        end
    end

    // Head memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re)
        begin
            head_rd_reg <= head_mem[head_raddr];
        end
    end

    // Link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[head_rd_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
